// ----- rtl/core/bracket_balance_checker_top_defines.svh -----
// Assertion macros for the bracket balance checker.
// Used by bracket_balance_checker_top only; no other dependencies.
`ifndef BRACKET_BALANCE_CHECKER_TOP_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define BBC_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BBC_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/bbc_pkg.sv -----
// Shared types and constants for the bracket balance checker.
// No dependencies; imported by every module of the block but bbc_ram.
package bbc_pkg;

   // input opcodes
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_EOL  = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNMATCHED = 3'd1;
   localparam logic [2:0] ST_WRONG     = 3'd2;
   localparam logic [2:0] ST_UNCLOSED  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   // bracket type codes held on the stack
   localparam logic [1:0] BR_NONE   = 2'd0;
   localparam logic [1:0] BR_ROUND  = 2'd1;
   localparam logic [1:0] BR_SQUARE = 2'd2;
   localparam logic [1:0] BR_CURLY  = 2'd3;

   // character codes
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_RND_OPEN = 8'h28;
   localparam logic [7:0] CH_SQR_OPEN = 8'h5B;
   localparam logic [7:0] CH_CRL_OPEN = 8'h7B;
   localparam logic [7:0] CH_RND_CLS  = 8'h29;
   localparam logic [7:0] CH_SQR_CLS  = 8'h5D;
   localparam logic [7:0] CH_CRL_CLS  = 8'h7D;

   // operation handed from front to back
   typedef enum logic [1:0] {
      KIND_NOP  = 2'd0,
      KIND_PUSH = 2'd1,
      KIND_POP  = 2'd2,
      KIND_EOL  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] btype;
   } item_type;

   // queue status seen by front and top
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [1:0] open_type(input logic [7:0] c);
      logic [1:0] t;
      t = BR_NONE;
      if (c == CH_RND_OPEN) t = BR_ROUND;
      if (c == CH_SQR_OPEN) t = BR_SQUARE;
      if (c == CH_CRL_OPEN) t = BR_CURLY;
      return t;
   endfunction

   function automatic logic [1:0] close_type(input logic [7:0] c);
      logic [1:0] t;
      t = BR_NONE;
      if (c == CH_RND_CLS) t = BR_ROUND;
      if (c == CH_SQR_CLS) t = BR_SQUARE;
      if (c == CH_CRL_CLS) t = BR_CURLY;
      return t;
   endfunction

endpackage

// ----- rtl/core/bbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the lower stack entries.
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bbc_front.sv -----
// Front end: takes input beats, resolves the colon escape, classifies bytes.
// Depends on bbc_pkg; feeds bbc_queue.
module bbc_front
   import bbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_opcode,
   input  logic [7:0] req_char_code,
   input  qstat_type q_stat,
   output logic      q_push,
   output item_type  q_item
);

   logic       colon_ff, colon_in;
   logic [1:0] otype, ctype;

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready;
   assign otype     = open_type(req_char_code);
   assign ctype     = close_type(req_char_code);

   // classify the byte and work out the escape flag
   always_comb begin
      q_item.btype = BR_NONE;
      q_item.kind  = KIND_NOP;
      colon_in     = colon_ff;
      if (q_push) begin
         if (req_opcode == OP_EOL) begin
            q_item.kind = KIND_EOL;
            colon_in    = 1'b0;
         end else if (colon_ff && (otype != BR_NONE || ctype != BR_NONE)) begin
            // escaped bracket: plain character
            colon_in = 1'b0;
         end else begin
            colon_in = (req_char_code == CH_COLON);
            if (otype != BR_NONE) begin
               q_item.kind  = KIND_PUSH;
               q_item.btype = otype;
            end else if (ctype != BR_NONE) begin
               q_item.kind  = KIND_POP;
               q_item.btype = ctype;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colon_ff <= 1'b0;
      end else begin
         colon_ff <= colon_in;
      end
   end

endmodule

// ----- rtl/core/bbc_queue.sv -----
// Two-entry queue of classified operations between front and back.
// Depends on bbc_pkg.
module bbc_queue
   import bbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  head,
   output qstat_type stat
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head       = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/bbc_back.sv -----
// Back end: stack push/pop, first-error tracking and the status output register.
// Depends on bbc_pkg and bbc_ram; consumes bbc_queue.
module bbc_back
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  item_type   head,
   input  qstat_type  q_stat,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status
);

   localparam int DepthW = $clog2(STACK_DEPTH + 1);
   localparam int AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [DepthW-1:0] depth_ff, depth_in;
   logic [2:0]        err_ff, err_in;
   logic [1:0]        top_ff, top_in;
   logic              byp_ff, byp_in;
   logic [1:0]        byp_data_ff, byp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;

   logic              wr_en;
   logic [DepthW-1:0] wr_idx, rd_idx;
   logic [1:0]        rd_data, second;
   logic              out_free;

   // top of stack lives in top_ff; the entry below comes from RAM or the bypass
   assign second   = byp_ff ? byp_data_ff : rd_data;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = !q_stat.empty && (head.kind != KIND_EOL || out_free);
   assign wr_idx   = depth_ff - DepthW'(1);
   assign rd_idx   = depth_in - DepthW'(2);

   // stack and error update for the head operation
   always_comb begin
      depth_in      = depth_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      byp_in        = byp_ff;
      byp_data_in   = byp_data_ff;
      wr_en         = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (q_pop) begin
         unique case (head.kind)
            KIND_PUSH: begin
               if (depth_ff < DepthW'(STACK_DEPTH)) begin
                  wr_en       = (depth_ff != '0);
                  top_in      = head.btype;
                  depth_in    = depth_ff + DepthW'(1);
                  byp_in      = 1'b1;
                  byp_data_in = top_ff;
               end else if (err_ff == ST_OK) begin
                  err_in = ST_OVERFLOW;
               end
            end
            KIND_POP: begin
               if (depth_ff == '0) begin
                  if (err_ff == ST_OK) err_in = ST_UNMATCHED;
               end else if (top_ff == head.btype) begin
                  depth_in = depth_ff - DepthW'(1);
                  top_in   = second;
                  byp_in   = 1'b0;
               end else if (err_ff == ST_OK) begin
                  err_in = ST_WRONG;
               end
            end
            KIND_EOL: begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  rsp_status_in = err_ff;
               end else if (depth_ff != '0) begin
                  rsp_status_in = ST_UNCLOSED;
               end else begin
                  rsp_status_in = ST_OK;
               end
               depth_in = '0;
               err_in   = ST_OK;
               byp_in   = 1'b0;
            end
            KIND_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= ST_OK;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      byp_data_ff   <= byp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   bbc_ram #(
      .WIDTH(2),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[AddrW-1:0]),
      .wr_data(top_ff),
      .rd_addr(rd_idx[AddrW-1:0]),
      .rd_data(rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- rtl/core/bracket_balance_checker_top.sv -----
// Bracket balance checker: one byte per beat, one status beat per line end.
// Takes one input beat every cycle, stalls only when the result register is held
// and a line end is waiting; a line's status passes through the queue and the result
// register after its end-of-line beat is taken. The front resolves colon escapes and
// classifies bytes into a two-entry queue; the back keeps the top of the stack in a
// register and the rest in a RAM with registered read, so a push or pop never waits
// on the RAM read. The stack RAM needs no clearing after reset. Status: 0 ok,
// 1 unmatched close, 2 wrong type, 3 unclosed open, 4 stack overflow.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back, bbc_ram and the defines header.
`include "bracket_balance_checker_top_defines.svh"

module bracket_balance_checker_top
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status
);

   qstat_type q_stat;
   item_type  q_item, q_head;
   logic      q_push, q_pop;

   bbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_char_code(req_char_code),
      .q_stat       (q_stat),
      .q_push       (q_push),
      .q_item       (q_item)
   );

   bbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_item(q_item),
      .pop      (q_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   bbc_back #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_status(rsp_status)
   );

   // checks
   `BBC_ASSERT_ANY(a_no_rsp_after_reset, reset |=> !rsp_valid, "result beat right after reset")
   `BBC_ASSERT_CLK(a_status_legal, rsp_valid |-> (rsp_status <= ST_OVERFLOW), "illegal status code")
   `BBC_ASSERT_CLK(a_queue_flags, !(q_stat.full && q_stat.empty), "queue both full and empty")
   `BBC_ASSERT_CLK(a_no_pop_empty, q_stat.empty |-> !q_pop, "queue popped while empty")

endmodule
